// File: hdl/mqpd_pkg.sv
// mqpd_pkg: payload types, result codes and fixed widths for the deque bank
// no dependencies; imported by every module of multi_queue_priority_deque
package mqpd_pkg;

  localparam int unsigned QIDX_W         = 5;
  localparam int unsigned TAG_W          = 16;
  localparam int unsigned COUNT_W        = 4;
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TAKE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    OUTC_DONE  = 2'd0,
    OUTC_FULL  = 2'd1,
    OUTC_EMPTY = 2'd2
  } outcome_t;

  typedef struct packed {
    logic              operation;
    logic [QIDX_W-1:0] queue_index;
    logic [TAG_W-1:0]  entry_tag;
    logic              urgent;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic [TAG_W-1:0]   taken_tag;
    logic               taken_urgent;
    logic [COUNT_W-1:0] queue_count;
  } out_item_t;

endpackage

// File: hdl/mqpd_front.sv
// mqpd_front: accepts items, keeps head/tail/count per queue, emits slot commands
// depends on mqpd_pkg; command type comes from the top level
module mqpd_front #(
  parameter int unsigned NUM_QUEUES  = 32,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned TAG_BITS    = 16,
  parameter type         cmd_t       = logic
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mqpd_pkg::in_item_t in_data,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output cmd_t               cmd
);
  import mqpd_pkg::*;

  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);

  logic [PW-1:0] head_r [NUM_QUEUES];
  logic [PW-1:0] tail_r [NUM_QUEUES];
  logic [CW-1:0] cnt_r  [NUM_QUEUES];

  logic [QW-1:0] qi;
  logic          in_range;
  logic [PW-1:0] h, t, h_nxt, t_nxt, slot, h_next, h_prev, t_next;
  logic [CW-1:0] n, n_nxt;
  logic          upd;
  logic          accept;

  assign qi       = QW'(in_data.queue_index);
  assign in_range = 32'(in_data.queue_index) < NUM_QUEUES;
  assign n        = in_range ? cnt_r[qi]  : '0;
  assign h        = in_range ? head_r[qi] : '0;
  assign t        = in_range ? tail_r[qi] : '0;

  // circular successor / predecessor
  assign h_next = (h == PW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
  assign t_next = (t == PW'(QUEUE_DEPTH - 1)) ? '0 : t + 1'b1;
  assign h_prev = (h == '0) ? PW'(QUEUE_DEPTH - 1) : h - 1'b1;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  always_comb begin
    cmd   = '0;
    upd   = 1'b0;
    h_nxt = h;
    t_nxt = t;
    n_nxt = n;
    slot  = '0;
    if (!in_range) begin
      cmd.outcome = (in_data.operation == OP_TAKE) ? OUTC_EMPTY : OUTC_FULL;
    end else if (in_data.operation == OP_ADD) begin
      if (n == CW'(QUEUE_DEPTH)) begin
        cmd.outcome = OUTC_FULL;
        cmd.count   = COUNT_W'(n);
      end else begin
        if (!in_data.urgent) begin
          t_nxt = t_next;
          h_nxt = (n == '0) ? t_next : h;
          slot  = t_next;
        end else begin
          h_nxt = (n == '0) ? t : h_prev;
          slot  = h_nxt;
        end
        n_nxt       = n + 1'b1;
        upd         = 1'b1;
        cmd.wr      = 1'b1;
        cmd.wdata   = {in_data.urgent, TAG_BITS'(in_data.entry_tag)};
        cmd.outcome = OUTC_DONE;
        cmd.count   = COUNT_W'(n_nxt);
      end
    end else begin
      if (n == '0) begin
        cmd.outcome = OUTC_EMPTY;
      end else begin
        slot        = h;
        h_nxt       = h_next;
        n_nxt       = n - 1'b1;
        upd         = 1'b1;
        cmd.rd      = 1'b1;
        cmd.outcome = OUTC_DONE;
        cmd.count   = COUNT_W'(n_nxt);
      end
    end
    cmd.addr = AW'(qi) * AW'(QUEUE_DEPTH) + AW'(slot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (accept && upd) begin
      head_r[qi] <= h_nxt;
      tail_r[qi] <= t_nxt;
      cnt_r[qi]  <= n_nxt;
    end
  end

endmodule

// File: hdl/mqpd_cmd_fifo.sv
// mqpd_cmd_fifo: short command queue between front and back
// depends on mqpd_pkg for its depth; entry type comes from the instantiator
module mqpd_cmd_fifo #(
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_data
);
  import mqpd_pkg::*;

  localparam int unsigned PW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMD_FIFO_DEPTH + 1);

  item_t         buf_r [CMD_FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push, pop;

  assign push_ready = (cnt_r != CW'(CMD_FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = buf_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: hdl/mqpd_back.sv
// mqpd_back: entry store access and registered result stage
// depends on mqpd_pkg; command type comes from the top level
module mqpd_back #(
  parameter int unsigned NUM_QUEUES  = 32,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned TAG_BITS    = 16,
  parameter type         cmd_t       = logic
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  cmd_t                cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output mqpd_pkg::out_item_t out_data
);
  import mqpd_pkg::*;

  localparam int unsigned SLOTS = NUM_QUEUES * QUEUE_DEPTH;

  logic [TAG_BITS:0]  store_mem [SLOTS];
  logic [TAG_BITS:0]  rd_data_r;
  logic               rd_r;
  logic [1:0]         outcome_r;
  logic [COUNT_W-1:0] count_r;
  logic               out_valid_r;
  logic               pop;

  assign cmd_ready = !out_valid_r || out_ready;
  assign pop       = cmd_valid && cmd_ready;

  // one write or one read per command, read data registered
  always_ff @(posedge clk) begin
    if (pop && cmd.wr) begin
      store_mem[cmd.addr] <= cmd.wdata;
    end
    if (pop && cmd.rd) begin
      rd_data_r <= store_mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_r      <= cmd.rd;
      outcome_r <= cmd.outcome;
      count_r   <= cmd.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_ready) begin
      out_valid_r <= cmd_valid;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_data.outcome      = outcome_r;
  assign out_data.taken_tag    = rd_r ? TAG_W'(rd_data_r[TAG_BITS-1:0]) : '0;
  assign out_data.taken_urgent = rd_r & rd_data_r[TAG_BITS];
  assign out_data.queue_count  = count_r;

endmodule

// File: hdl/multi_queue_priority_deque.sv
// multi_queue_priority_deque: top level of the bank of circular deques
// depends on mqpd_pkg, mqpd_front, mqpd_cmd_fifo, mqpd_back
//
// usage
//   in_* channel: one beat is one item (add or take) aimed at one queue
//   out_* channel: exactly one result beat per item, in item order
//   an add puts its tag at the back, or at the front when urgent; a full
//   queue refuses it; a take pops the front entry or reports empty
//   every result carries the addressed queue's count after the item
// timing
//   an accepted item passes the command queue, then the back's registered result stage, before its beat shows on out_*
//   sustained rate is one item per cycle while out_ready stays high: the front
//   does the per-queue pointer update in the accept cycle, the back does one
//   store access per cycle on a single-port entry memory
//   a two-entry command queue sits between front and back; when out_ready
//   stays low the result register holds, the queue fills and in_ready falls
// reset
//   synchronous rst_n empties every queue at once; the entry memory is not
//   cleared, only slots that were written are ever read back
module multi_queue_priority_deque #(
  parameter int unsigned NUM_QUEUES  = 32,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mqpd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mqpd_pkg::out_item_t out_data
);
  import mqpd_pkg::*;

  localparam int unsigned AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);

  // command from front to back: at most one store access plus the result fields
  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [AW-1:0]      addr;
    logic [TAG_BITS:0]  wdata;
    outcome_t           outcome;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  // front: classify item, update head/tail/count
  mqpd_front #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .cmd_t       (cmd_t)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // decoupling queue
  mqpd_cmd_fifo #(
    .item_t (cmd_t)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cmd)
  );

  // back: entry store and result register
  mqpd_back #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .cmd_t       (cmd_t)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hdl/mqpd_checker.sv
// mqpd_checker: port-level assertions for multi_queue_priority_deque, bound to the top
// depends on mqpd_pkg and multi_queue_priority_deque
module mqpd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input mqpd_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input mqpd_pkg::out_item_t out_data
);
  import mqpd_pkg::*;

  // a waiting input beat stays offered with its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat withdrawn or changed while waiting");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // refused or empty results carry no taken entry
  a_no_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome != OUTC_DONE |->
      out_data.taken_tag == '0 && !out_data.taken_urgent)
    else $error("taken entry on a result that took nothing");

  // an empty report always shows a zero count
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outcome == OUTC_EMPTY |-> out_data.queue_count == '0)
    else $error("empty result with nonzero count");

endmodule

bind multi_queue_priority_deque mqpd_checker u_mqpd_checker (.*);
